// ===== sv/tbo_pkg.sv =====
// Shared types and constants for the transform blend / orthonormalize block.
// Depends on nothing; imported by every module of the block.
package tbo_pkg;

    localparam int FRAC_BITS = 16;
    localparam int N_ELEM    = 12;
    localparam int DIV_W     = 32 + FRAC_BITS;

    // Alpha clamp ceiling, 1.0 in Q.FRAC_BITS
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    // Short-row threshold, 1e-6 in Q.(2*FRAC_BITS), rounded to nearest
    localparam logic [63:0] EPS_Q =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;

    // Request command codes
    localparam logic [1:0] CMD_LOAD_PREV = 2'd0;
    localparam logic [1:0] CMD_LOAD_CUR  = 2'd1;
    localparam logic [1:0] CMD_INTERP    = 2'd2;

    localparam logic [3:0] LAST_ELEM = 4'd11;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] blend_factor;
    } request_t;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] out_value;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLEND,
        S_NSUM,
        S_NSQRT,
        S_NDIV,
        S_PROJ,
        S_PSUB,
        S_CROSS,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_BLD,
        OP_LDA,
        OP_LDB,
        OP_LDAB,
        OP_LDPL,
        OP_LDPH,
        OP_MUL,
        OP_ASET,
        OP_AADD,
        OP_ASUB,
        OP_AADDH,
        OP_BWR,
        OP_PSET,
        OP_PSUB,
        OP_XWR,
        OP_SQRT_GO,
        OP_DIV_GO,
        OP_DWR,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
    } dp_status_t;

endpackage

// ===== sv/tbo_isqrt.sv =====
// Bit-pair-per-cycle integer square root of a 64-bit radicand.
// Depends on tbo_pkg.
module tbo_isqrt
    import tbo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] n_reg, n_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    // Run one digit step while the bit mask is nonzero
    always_comb
    begin
        n_next   = n_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        trial    = res_reg + bit_reg;
        if (go)
        begin
            n_next   = radicand;
            res_next = 64'd0;
            bit_next = 64'd1 << 62;
        end
        else if (bit_reg != 64'd0)
        begin
            if (n_reg >= trial)
            begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 64'd0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
    end

    assign busy = (bit_reg != 64'd0);
    assign root = res_reg[31:0];

endmodule

// ===== sv/tbo_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tbo_pkg (DIV_W).
module tbo_div
    import tbo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DIV_W-1:0] dividend,
    input  logic [31:0]      divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [32:0]      shifted;
    logic [32:0]      diff;

    // Shift in one dividend bit, subtract where it fits
    always_comb
    begin
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        shifted  = {rem_reg, dq_reg[DIV_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        if (go)
        begin
            dq_next  = dividend;
            rem_next = 32'd0;
            dvs_next = divisor;
            cnt_next = CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                dq_next  = {dq_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                dq_next  = {dq_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = dq_reg;

endmodule

// ===== sv/tbo_dpath.sv =====
// Datapath: matrix stores, shared multiplier, accumulator, root and divider.
// Depends on tbo_pkg, tbo_isqrt and tbo_div.
module tbo_dpath
    import tbo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  request_t   request,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       strobe,
    output result_t    result
);

    logic signed [31:0] prev_reg [N_ELEM];
    logic signed [31:0] cur_reg  [N_ELEM];
    logic signed [31:0] m_reg    [N_ELEM];

    logic [FRAC_BITS:0]  alpha_reg, alpha_next;
    logic signed [32:0]  a_reg, a_next;
    logic signed [32:0]  b_reg, b_next;
    logic signed [31:0]  t_reg, t_next;
    logic signed [65:0]  prod_reg, prod_next;
    logic [63:0]         acc_reg, acc_next;
    logic [63:0]         p_reg, p_next;
    logic                skip_reg, skip_next;
    logic                neg_reg, neg_next;
    logic                strobe_reg, strobe_next;
    result_t             result_reg, result_next;

    logic signed [31:0]  rd_m;
    logic signed [31:0]  rd_prev;
    logic signed [31:0]  rd_cur;
    logic signed [63:0]  acc_shift;
    logic signed [65:0]  prod_shift;
    logic                m_we;
    logic signed [31:0]  m_wr_data;
    logic [31:0]         abs_m;
    logic [65:0]         q_signed;
    logic                sqrt_go;
    logic                sqrt_busy;
    logic [31:0]         root;
    logic                div_go;
    logic                div_busy;
    logic [DIV_W-1:0]    quotient;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (!v[65] && (|v[64:31]))
            r = 32'sh7FFFFFFF;
        else if (v[65] && !(&v[64:31]))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    assign rd_m       = m_reg[cmd.idx];
    assign rd_prev    = prev_reg[cmd.idx];
    assign rd_cur     = cur_reg[cmd.idx];
    assign acc_shift  = $signed(acc_reg) >>> FRAC_BITS;
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign abs_m      = rd_m[31] ? 32'(-rd_m) : 32'(rd_m);
    assign q_signed   = neg_reg ? (66'd0 - {{(66-DIV_W){1'b0}}, quotient})
                                : {{(66-DIV_W){1'b0}}, quotient};
    assign sqrt_go    = (cmd.op == OP_SQRT_GO);
    assign div_go     = (cmd.op == OP_DIV_GO);

    // Decode the micro-op into register updates
    always_comb
    begin
        alpha_next  = alpha_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        t_next      = t_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        p_next      = p_reg;
        skip_next   = skip_reg;
        neg_next    = neg_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        m_we        = 1'b0;
        m_wr_data   = rd_m;

        // Clamp alpha when an interpolate request is taken
        if (accept && request.command == CMD_INTERP)
        begin
            if (request.blend_factor[31])
                alpha_next = '0;
            else if (request.blend_factor > ONE_Q)
                alpha_next = ONE_Q[FRAC_BITS:0];
            else
                alpha_next = request.blend_factor[FRAC_BITS:0];
        end

        unique case (cmd.op)
            OP_BLD:
            begin
                a_next = {rd_cur[31], rd_cur} - {rd_prev[31], rd_prev};
                b_next = {{(32-FRAC_BITS){1'b0}}, alpha_reg};
                t_next = rd_prev;
            end
            OP_LDA:
                a_next = {rd_m[31], rd_m};
            OP_LDB:
                b_next = {rd_m[31], rd_m};
            OP_LDAB:
            begin
                a_next = {rd_m[31], rd_m};
                b_next = {rd_m[31], rd_m};
            end
            OP_LDPL:
                b_next = {1'b0, p_reg[31:0]};
            OP_LDPH:
                b_next = {p_reg[63], p_reg[63:32]};
            OP_MUL:
                prod_next = a_reg * b_reg;
            OP_ASET:
                acc_next = prod_reg[63:0];
            OP_AADD:
                acc_next = acc_reg + prod_reg[63:0];
            OP_ASUB:
                acc_next = acc_reg - prod_reg[63:0];
            OP_AADDH:
                acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            OP_BWR:
            begin
                m_we      = 1'b1;
                m_wr_data = sat32($signed({{34{t_reg[31]}}, t_reg}) + prod_shift);
            end
            OP_PSET:
                p_next = acc_shift;
            OP_PSUB:
            begin
                m_we      = 1'b1;
                m_wr_data = sat32({{34{rd_m[31]}}, rd_m}
                                  - {{2{acc_shift[63]}}, acc_shift});
            end
            OP_XWR:
            begin
                m_we      = 1'b1;
                m_wr_data = sat32({{2{acc_shift[63]}}, acc_shift});
            end
            OP_SQRT_GO:
                skip_next = (acc_reg < EPS_Q);
            OP_DIV_GO:
                neg_next = rd_m[31];
            OP_DWR:
            begin
                m_we      = !skip_reg;
                m_wr_data = sat32(q_signed);
            end
            OP_EMIT:
            begin
                strobe_next           = 1'b1;
                result_next.out_index = cmd.idx;
                result_next.out_value = rd_m;
                result_next.last      = (cmd.idx == LAST_ELEM);
            end
            default:
            begin
            end
        endcase
    end

    // Load matrix elements, out-of-range indexes drop; write back the working matrix
    always_ff @(posedge clk)
    begin
        if (accept && request.element_index <= LAST_ELEM)
        begin
            if (request.command == CMD_LOAD_PREV)
                prev_reg[request.element_index] <= request.element_value;
            else if (request.command == CMD_LOAD_CUR)
                cur_reg[request.element_index] <= request.element_value;
        end
        if (m_we)
            m_reg[cmd.idx] <= m_wr_data;
    end

    always_ff @(posedge clk)
    begin
        alpha_reg  <= alpha_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        t_reg      <= t_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        p_reg      <= p_next;
        skip_reg   <= skip_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    tbo_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sqrt_go),
        .radicand (acc_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    tbo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend ({abs_m, {FRAC_BITS{1'b0}}}),
        .divisor  (root),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.sqrt_busy = sqrt_busy;
    assign status.div_busy  = div_busy;
    assign strobe           = strobe_reg;
    assign result           = result_reg;

endmodule

// ===== sv/tbo_ctrl.sv =====
// Controller: sequences blend, normalize, projection, cross product, output.
// Depends on tbo_pkg.
module tbo_ctrl
    import tbo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] command,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3:0] sub_reg, sub_next;
    logic [1:0] row_reg, row_next;
    logic [3:0] base;

    // Operand indexes of the cross product: sel 0..3 is a1, b1, a2, b2
    function automatic logic [3:0] cross_idx(input logic [3:0] k, input logic [1:0] sel);
        logic [3:0] r;
        r = 4'd0;
        case (k)
            4'd0:
                case (sel)
                    2'd0: r = 4'd1;
                    2'd1: r = 4'd5;
                    2'd2: r = 4'd2;
                    default: r = 4'd4;
                endcase
            4'd1:
                case (sel)
                    2'd0: r = 4'd2;
                    2'd1: r = 4'd3;
                    2'd2: r = 4'd0;
                    default: r = 4'd5;
                endcase
            default:
                case (sel)
                    2'd0: r = 4'd0;
                    2'd1: r = 4'd4;
                    2'd2: r = 4'd1;
                    default: r = 4'd3;
                endcase
        endcase
        return r;
    endfunction

    always_comb
    begin
        case (row_reg)
            2'd0:    base = 4'd0;
            2'd1:    base = 4'd3;
            default: base = 4'd6;
        endcase
    end

    // Next state and micro-op
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sub_next   = sub_reg;
        row_next   = row_reg;
        cmd.op     = OP_NOP;
        cmd.idx    = 4'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && command == CMD_INTERP)
                begin
                    state_next = S_BLEND;
                    cnt_next   = 4'd0;
                    sub_next   = 4'd0;
                    row_next   = 2'd0;
                end
            end
            S_BLEND:
            begin
                cmd.idx = cnt_reg;
                case (sub_reg)
                    4'd0:    cmd.op = OP_BLD;
                    4'd1:    cmd.op = OP_MUL;
                    default: cmd.op = OP_BWR;
                endcase
                if (sub_reg == 4'd2)
                begin
                    sub_next = 4'd0;
                    if (cnt_reg == LAST_ELEM)
                    begin
                        cnt_next   = 4'd0;
                        state_next = S_NSUM;
                    end
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
                else
                    sub_next = sub_reg + 4'd1;
            end
            S_NSUM:
            begin
                cmd.idx = base + cnt_reg;
                case (sub_reg)
                    4'd0:    cmd.op = OP_LDAB;
                    4'd1:    cmd.op = OP_MUL;
                    default: cmd.op = (cnt_reg == 4'd0) ? OP_ASET : OP_AADD;
                endcase
                if (sub_reg == 4'd2)
                begin
                    sub_next = 4'd0;
                    if (cnt_reg == 4'd2)
                    begin
                        cnt_next   = 4'd0;
                        state_next = S_NSQRT;
                    end
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
                else
                    sub_next = sub_reg + 4'd1;
            end
            S_NSQRT:
            begin
                if (sub_reg == 4'd0)
                begin
                    cmd.op   = OP_SQRT_GO;
                    sub_next = 4'd1;
                end
                else if (!status.sqrt_busy)
                begin
                    sub_next   = 4'd0;
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                cmd.idx = base + cnt_reg;
                case (sub_reg)
                    4'd0:
                    begin
                        cmd.op   = OP_DIV_GO;
                        sub_next = 4'd1;
                    end
                    4'd1:
                    begin
                        if (!status.div_busy)
                            sub_next = 4'd2;
                    end
                    default:
                    begin
                        cmd.op   = OP_DWR;
                        sub_next = 4'd0;
                        if (cnt_reg == 4'd2)
                        begin
                            cnt_next = 4'd0;
                            case (row_reg)
                                2'd0:    state_next = S_PROJ;
                                2'd1:    state_next = S_CROSS;
                                default: state_next = S_OUT;
                            endcase
                        end
                        else
                            cnt_next = cnt_reg + 4'd1;
                    end
                endcase
            end
            S_PROJ:
            begin
                case (sub_reg)
                    4'd0:
                    begin
                        cmd.op   = OP_LDA;
                        cmd.idx  = 4'd3 + cnt_reg;
                        sub_next = 4'd1;
                    end
                    4'd1:
                    begin
                        cmd.op   = OP_LDB;
                        cmd.idx  = cnt_reg;
                        sub_next = 4'd2;
                    end
                    4'd2:
                    begin
                        cmd.op   = OP_MUL;
                        sub_next = 4'd3;
                    end
                    4'd3:
                    begin
                        cmd.op = (cnt_reg == 4'd0) ? OP_ASET : OP_AADD;
                        if (cnt_reg == 4'd2)
                            sub_next = 4'd4;
                        else
                        begin
                            sub_next = 4'd0;
                            cnt_next = cnt_reg + 4'd1;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_PSET;
                        sub_next   = 4'd0;
                        cnt_next   = 4'd0;
                        state_next = S_PSUB;
                    end
                endcase
            end
            S_PSUB:
            begin
                cmd.idx = cnt_reg;
                case (sub_reg)
                    4'd0:    cmd.op = OP_LDA;
                    4'd1:    cmd.op = OP_LDPL;
                    4'd2:    cmd.op = OP_MUL;
                    4'd3:    cmd.op = OP_ASET;
                    4'd4:    cmd.op = OP_LDPH;
                    4'd5:    cmd.op = OP_MUL;
                    4'd6:    cmd.op = OP_AADDH;
                    default:
                    begin
                        cmd.op  = OP_PSUB;
                        cmd.idx = 4'd3 + cnt_reg;
                    end
                endcase
                if (sub_reg == 4'd7)
                begin
                    sub_next = 4'd0;
                    if (cnt_reg == 4'd2)
                    begin
                        cnt_next   = 4'd0;
                        row_next   = 2'd1;
                        state_next = S_NSUM;
                    end
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
                else
                    sub_next = sub_reg + 4'd1;
            end
            S_CROSS:
            begin
                case (sub_reg)
                    4'd0:
                    begin
                        cmd.op  = OP_LDA;
                        cmd.idx = cross_idx(cnt_reg, 2'd0);
                    end
                    4'd1:
                    begin
                        cmd.op  = OP_LDB;
                        cmd.idx = cross_idx(cnt_reg, 2'd1);
                    end
                    4'd2:    cmd.op = OP_MUL;
                    4'd3:    cmd.op = OP_ASET;
                    4'd4:
                    begin
                        cmd.op  = OP_LDA;
                        cmd.idx = cross_idx(cnt_reg, 2'd2);
                    end
                    4'd5:
                    begin
                        cmd.op  = OP_LDB;
                        cmd.idx = cross_idx(cnt_reg, 2'd3);
                    end
                    4'd6:    cmd.op = OP_MUL;
                    4'd7:    cmd.op = OP_ASUB;
                    default:
                    begin
                        cmd.op  = OP_XWR;
                        cmd.idx = 4'd6 + cnt_reg;
                    end
                endcase
                if (sub_reg == 4'd8)
                begin
                    sub_next = 4'd0;
                    if (cnt_reg == 4'd2)
                    begin
                        cnt_next   = 4'd0;
                        row_next   = 2'd2;
                        state_next = S_NSUM;
                    end
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
                else
                    sub_next = sub_reg + 4'd1;
            end
            S_OUT:
            begin
                cmd.op  = OP_EMIT;
                cmd.idx = cnt_reg;
                if (cnt_reg == LAST_ELEM)
                begin
                    cnt_next   = 4'd0;
                    state_next = S_IDLE;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 4'd0;
            sub_reg   <= 4'd0;
            row_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
            row_reg   <= row_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== sv/transform_blend_orthonormalize.sv =====
// Blend of two 4x3 rigid transforms with Gram-Schmidt re-orthonormalization.
// Loads give no result. An interpolate uses a one-bit-per-cycle square root (32
// steps) and divider (48 steps), run once and three times per normalized row;
// results then stream one per cycle, twelve in all.
// One request at a time; the receiver cannot stall. Reset clears control only;
// matrix stores are undefined until written.
module transform_blend_orthonormalize
    import tbo_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     strobe,
    output result_t  result
);

    logic       accept;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Take a request only when the sequencer is idle
    assign accept = start & ~busy;

    tbo_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (request.command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    tbo_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

// ===== sv/tbo_checker.sv =====
// Port-level checks on the result stream and interpolate start of the blend block, and its bind.
// Depends on tbo_pkg and transform_blend_orthonormalize.
module tbo_checker
    import tbo_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input request_t request,
    input logic     strobe,
    input result_t  result
);

    // Results of one interpolate come in back-to-back cycles
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("result stream broke before last");

    // Indexes count up by one within a stream
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> result.out_index == $past(result.out_index) + 4'd1)
        else $error("result index did not advance");

    // Last marks element eleven
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |-> result.out_index == LAST_ELEM)
        else $error("last on wrong index");

    // Block stays busy while results are still due
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("idle with results pending");

    // Interpolate request raises busy
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.command == CMD_INTERP |=> busy)
        else $error("interpolate not started");

endmodule

bind transform_blend_orthonormalize tbo_checker u_tbo_checker (.*);
